>>> sv/uesc_pkg.sv
// Shared types, constants and helpers for the escape-to-UTF-8 converter.
`timescale 1ns / 1ps

package uesc_pkg;

   // Character codes
   localparam logic [7:0] BSL_CHAR   = 8'h5C;
   localparam logic [7:0] LOWER_U    = 8'h75;
   localparam logic [7:0] UPPER_U    = 8'h55;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   // UTF-8 lead and continuation bytes
   localparam logic [7:0] UTF_LEAD3  = 8'hE0;
   localparam logic [7:0] UTF_LEAD4  = 8'hF0;
   localparam logic [7:0] UTF_CONT   = 8'h80;

   // Escape tail held for the end-of-string rescan
   localparam int TAIL_MAX    = 7;
   localparam int TAIL_CNT_W  = $clog2(TAIL_MAX + 1);
   localparam int CHARS_W     = 8 * TAIL_MAX;
   localparam int VALUE_W     = 21;

   // Command queue between front and back
   localparam int Q_DEPTH     = 2;
   localparam int Q_IDX_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   // Command kinds
   localparam logic [1:0] CMD_LIT = 2'd0;
   localparam logic [1:0] CMD_U4  = 2'd1;
   localparam logic [1:0] CMD_U8  = 2'd2;
   localparam logic [1:0] CMD_END = 2'd3;

   typedef struct packed {
      logic [1:0]            kind;
      logic [7:0]            lit;         // literal byte, or prefix letter on END
      logic                  has_prefix;  // END: emit lit first
      logic [TAIL_CNT_W-1:0] count;       // END: chars to rescan
      logic [CHARS_W-1:0]    chars;       // END: collected chars, first in low byte
      logic [VALUE_W-1:0]    value;       // U4/U8: code point bits kept
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // Non-hex characters count as zero
   function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
      logic [3:0] r;
      r = 4'h0;
      if (ch inside {[8'h30:8'h39]}) begin
         r = ch[3:0];
      end else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r = ch[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

>>> sv/unicode_escape_to_utf8.sv
// Top level: streaming converter of backslash escapes to UTF-8 bytes.
// Path: a literal word goes through a queue entry and the output register; escape bytes go
//   through the UTF-8 sequencer into the output register. Throughput: one literal per cycle
//   unless rsp_tready stalls; a u/U-escape is popped, then emits 3/4 words; the terminator
//   emits the u/U letter after an open escape, then the rescanned chars, then a NUL word.
// Reset: synchronous, active high; clears parse mode, queue, sequencer and output valid.
`timescale 1ns / 1ps

module unicode_escape_to_utf8
   import uesc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input text stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   // output byte stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last word caused by one input word
   output logic       rsp_tuser    // [0] string_end
);

   // front -> queue
   logic         push;
   cmd_type      push_cmd;

   // queue -> back
   logic         pop;
   cmd_type      head_cmd;
   q_status_type q_status;

   // Front end classifies every input word: literals go straight to the
   // queue, escape digits collect in a small tail buffer until a complete
   // escape is queued; a terminator ships the unfinished tail to rescan.
   uesc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Two-entry queue lets the front keep taking words while the back
   // expands a multi-byte escape.
   uesc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Back end emits at most one output word per cycle into the output register, as rsp_tready allows.
   uesc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> sv/uesc_front.sv
// Front end: takes input words, tracks escape state, issues commands.
`timescale 1ns / 1ps

module uesc_front
   import uesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_BSLASH = 2'd1;
   localparam logic [1:0] MODE_U4     = 2'd2;
   localparam logic [1:0] MODE_U8     = 2'd3;

   logic [1:0] mode_ff, mode_in;
   logic [3:0] digits_ff, digits_in;
   logic [7:0] buf_ff [TAIL_MAX];

   logic                  accept;
   logic                  buf_wr_en;
   logic [TAIL_CNT_W-1:0] buf_wr_idx;
   logic [CHARS_W-1:0]    tail_chars;
   logic [3:0]            cur_nib;
   logic [3:0]            nib2;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign buf_wr_idx = digits_ff[TAIL_CNT_W-1:0];
   assign cur_nib    = hex_nibble(req_tdata);
   assign nib2       = hex_nibble(buf_ff[2]);

   always_comb begin
      for (int i = 0; i < TAIL_MAX; i++) begin
         tail_chars[8*i +: 8] = buf_ff[i];
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      digits_in      = digits_ff;
      buf_wr_en      = 1'b0;
      push           = 1'b0;
      push_cmd       = '0;
      push_cmd.lit   = req_tdata;
      push_cmd.chars = tail_chars;
      if (accept) begin
         if (req_tdata == NUL_CHAR) begin
            push                = 1'b1;
            push_cmd.kind       = CMD_END;
            push_cmd.has_prefix = (mode_ff == MODE_U4) || (mode_ff == MODE_U8);
            push_cmd.lit        = (mode_ff == MODE_U4) ? LOWER_U : UPPER_U;
            push_cmd.count      = push_cmd.has_prefix ? digits_ff[TAIL_CNT_W-1:0] : '0;
            mode_in             = MODE_NORMAL;
            digits_in           = 4'd0;
         end else begin
            case (mode_ff)
               MODE_NORMAL: begin
                  if (req_tdata == BSL_CHAR) begin
                     mode_in = MODE_BSLASH;
                  end else begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_LIT;
                  end
               end
               MODE_BSLASH: begin
                  digits_in = 4'd0;
                  if (req_tdata == LOWER_U) begin
                     mode_in = MODE_U4;
                  end else if (req_tdata == UPPER_U) begin
                     mode_in = MODE_U8;
                  end else begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_LIT;
                     mode_in       = MODE_NORMAL;
                  end
               end
               MODE_U4: begin
                  if (digits_ff == 4'd3) begin
                     push           = 1'b1;
                     push_cmd.kind  = CMD_U4;
                     push_cmd.value = {5'd0, hex_nibble(buf_ff[0]), hex_nibble(buf_ff[1]),
                                       hex_nibble(buf_ff[2]), cur_nib};
                     mode_in        = MODE_NORMAL;
                     digits_in      = 4'd0;
                  end else begin
                     buf_wr_en = 1'b1;
                     digits_in = digits_ff + 4'd1;
                  end
               end
               MODE_U8: begin
                  if (digits_ff == 4'd7) begin
                     push           = 1'b1;
                     push_cmd.kind  = CMD_U8;
                     push_cmd.value = {nib2[0], hex_nibble(buf_ff[3]),
                                       hex_nibble(buf_ff[4]), hex_nibble(buf_ff[5]),
                                       hex_nibble(buf_ff[6]), cur_nib};
                     mode_in        = MODE_NORMAL;
                     digits_in      = 4'd0;
                  end else begin
                     buf_wr_en = 1'b1;
                     digits_in = digits_ff + 4'd1;
                  end
               end
               default: begin
                  mode_in = MODE_NORMAL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         digits_ff <= 4'd0;
      end else begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
      end
   end

   // Tail buffer: payload only, written before it is ever read
   always_ff @(posedge clock) begin
      if (buf_wr_en) begin
         buf_ff[buf_wr_idx] <= req_tdata;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_U4) |-> (digits_ff < 4'd4))
      else $error("u-escape digit count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NORMAL) || (mode_ff == MODE_BSLASH) |-> (digits_ff == 4'd0))
      else $error("digit count left over outside an escape");

endmodule

>>> sv/uesc_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module uesc_queue
   import uesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   localparam logic [Q_IDX_W-1:0] LAST_IDX = Q_IDX_W'(Q_DEPTH - 1);

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("pop from an empty queue");

endmodule

>>> sv/uesc_back.sv
// Back end: expands commands into output words and drives the output register.
`timescale 1ns / 1ps

module uesc_back
   import uesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head_cmd,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tuser
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_UTF  = 2'd1;
   localparam logic [1:0] S_PFX  = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [2:0]            left_ff, left_in;
   logic                  wide_ff, wide_in;
   logic                  flush_ff, flush_in;
   logic [7:0]            prefix_ff, prefix_in;
   logic [CHARS_W-1:0]    chars_ff, chars_in;
   logic [TAIL_CNT_W-1:0] count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  adv;
   logic                  em_valid;
   logic [7:0]            em_byte;
   logic                  em_last;
   logic                  em_end;
   logic [7:0]            utf_byte;
   logic [7:0]            c0, c1;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign c0  = chars_ff[7:0];
   assign c1  = chars_ff[15:8];

   // Byte of the UTF-8 sequence picked by the remaining count
   always_comb begin
      case (left_ff)
         3'd4:    utf_byte = UTF_LEAD4 | {5'd0, value_ff[20:18]};
         3'd3:    utf_byte = wide_ff ? (UTF_CONT | {2'd0, value_ff[17:12]})
                                     : (UTF_LEAD3 | {4'd0, value_ff[15:12]});
         3'd2:    utf_byte = UTF_CONT | {2'd0, value_ff[11:6]};
         3'd1:    utf_byte = UTF_CONT | {2'd0, value_ff[5:0]};
         default: utf_byte = 8'd0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      value_in  = value_ff;
      left_in   = left_ff;
      wide_in   = wide_ff;
      flush_in  = flush_ff;
      prefix_in = prefix_ff;
      chars_in  = chars_ff;
      count_in  = count_ff;
      pop       = 1'b0;
      em_valid  = 1'b0;
      em_byte   = 8'd0;
      em_last   = 1'b0;
      em_end    = 1'b0;
      if (adv) begin
         case (state_ff)
            S_IDLE: begin
               if (!q_status.empty) begin
                  pop = 1'b1;
                  case (head_cmd.kind)
                     CMD_LIT: begin
                        em_valid = 1'b1;
                        em_byte  = head_cmd.lit;
                        em_last  = 1'b1;
                     end
                     CMD_U4: begin
                        value_in = head_cmd.value;
                        left_in  = 3'd3;
                        wide_in  = 1'b0;
                        flush_in = 1'b0;
                        state_in = S_UTF;
                     end
                     CMD_U8: begin
                        value_in = head_cmd.value;
                        left_in  = 3'd4;
                        wide_in  = 1'b1;
                        flush_in = 1'b0;
                        state_in = S_UTF;
                     end
                     CMD_END: begin
                        chars_in  = head_cmd.chars;
                        count_in  = head_cmd.count;
                        prefix_in = head_cmd.lit;
                        flush_in  = 1'b1;
                        state_in  = head_cmd.has_prefix ? S_PFX : S_SCAN;
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
            S_UTF: begin
               em_valid = 1'b1;
               em_byte  = utf_byte;
               em_last  = (left_ff == 3'd1) && !flush_ff;
               left_in  = left_ff - 3'd1;
               if (left_ff == 3'd1) begin
                  state_in = flush_ff ? S_SCAN : S_IDLE;
               end
            end
            S_PFX: begin
               em_valid = 1'b1;
               em_byte  = prefix_ff;
               state_in = S_SCAN;
            end
            S_SCAN: begin
               if (count_ff == '0) begin
                  // string terminator closes the run
                  em_valid = 1'b1;
                  em_byte  = NUL_CHAR;
                  em_last  = 1'b1;
                  em_end   = 1'b1;
                  flush_in = 1'b0;
                  state_in = S_IDLE;
               end else if (c0 != BSL_CHAR) begin
                  em_valid = 1'b1;
                  em_byte  = c0;
                  chars_in = chars_ff >> 8;
                  count_in = count_ff - 1'b1;
               end else if (count_ff >= TAIL_CNT_W'(2) && c1 == BSL_CHAR) begin
                  em_valid = 1'b1;
                  em_byte  = BSL_CHAR;
                  chars_in = chars_ff >> 16;
                  count_in = count_ff - TAIL_CNT_W'(2);
               end else if (count_ff >= TAIL_CNT_W'(6) && c1 == LOWER_U) begin
                  // complete u-escape inside the tail
                  value_in = {5'd0, hex_nibble(chars_ff[23:16]), hex_nibble(chars_ff[31:24]),
                              hex_nibble(chars_ff[39:32]), hex_nibble(chars_ff[47:40])};
                  left_in  = 3'd3;
                  wide_in  = 1'b0;
                  chars_in = chars_ff >> 48;
                  count_in = count_ff - TAIL_CNT_W'(6);
                  state_in = S_UTF;
               end else begin
                  // lone backslash dropped
                  chars_in = chars_ff >> 8;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (adv) begin
         rsp_valid_in = em_valid;
         rsp_data_in  = em_byte;
         rsp_last_in  = em_last;
         rsp_user_in  = em_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flush_ff     <= 1'b0;
         left_ff      <= 3'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      wide_ff     <= wide_in;
      prefix_ff   <= prefix_in;
      chars_ff    <= chars_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_last_ff && rsp_data_ff == NUL_CHAR))
      else $error("terminator word not closing its run");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UTF) |-> (left_ff != 3'd0))
      else $error("UTF-8 sequencer active with nothing left");

endmodule
